FILE: design/ipag_pkg.sv
// Shared types, constants and helpers for the image patch address generator.
`timescale 1ns / 1ps

package ipag_pkg;

  localparam int KERNEL_H  = 3;
  localparam int KERNEL_W  = 3;
  localparam int MAX_BATCH = 16;

  localparam int DIM_W      = 13;
  localparam int CH_W       = 11;
  localparam int STEP_W     = 7;
  localparam int MODE_W     = 2;
  localparam int BATCH_W    = 4;
  localparam int POS_W      = 12;
  localparam int TAP_W      = 2;
  localparam int CHAN_W     = 10;
  localparam int SRC_W      = 38;
  localparam int OCH_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int KMAX     = (KERNEL_H > KERNEL_W) ? KERNEL_H : KERNEL_W;
  localparam int SPAN_W   = $clog2(KMAX * 128);
  localparam int TOT_W    = SPAN_W + 2;
  localparam int RPROD_W  = POS_W + STEP_W;
  localparam int TPROD_W  = TAP_W + STEP_W;
  localparam int ROW_W    = RPROD_W + 2;
  localparam int BC_W     = BATCH_W + CH_W;
  localparam int BCC_W    = BC_W + 1;
  localparam int P2_W     = BCC_W + DIM_W;
  localparam int TAPI_W   = 8;
  localparam int OCHP_W   = TAPI_W + CH_W;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_ROWS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_COLS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODE    = 3'd7;

  localparam logic [MODE_W-1:0] PAD_VALID      = 2'd0;
  localparam logic [MODE_W-1:0] PAD_SAME_LOWER = 2'd1;
  localparam logic [MODE_W-1:0] PAD_SAME_UPPER = 2'd2;

  typedef struct packed {
    logic [BATCH_W-1:0] batch;
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic [TAP_W-1:0]   kernel_row;
    logic [TAP_W-1:0]   kernel_col;
    logic [CHAN_W-1:0]  channel;
  } in_word_t;

  typedef struct packed {
    logic [SRC_W-1:0] src_index;
    logic             is_padding;
    logic [OCH_W-1:0] out_channel;
  } out_word_t;

  typedef struct packed {
    logic [RPROD_W-1:0] rprod;
    logic [TPROD_W-1:0] rtap;
    logic [RPROD_W-1:0] cprod;
    logic [TPROD_W-1:0] ctap;
    logic [BC_W-1:0]    bc;
    logic [CHAN_W-1:0]  chan;
    logic [OCH_W-1:0]   och;
  } fq_word_t;

  typedef struct packed {
    logic [DIM_W-1:0]  height;
    logic [DIM_W-1:0]  width;
    logic [SPAN_W-1:0] pad_top;
    logic [SPAN_W-1:0] pad_left;
  } geom_t;

  function automatic logic [BATCH_W-1:0] batch_mod(input logic [BATCH_W-1:0] b);
    logic [BATCH_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << BATCH_W); i++) begin
      if (b == BATCH_W'(i)) r = BATCH_W'(i % MAX_BATCH);
    end
    return r;
  endfunction

endpackage

FILE: design/ipag_pad_unit.sv
// Iterative padding calculator for one image axis.
`timescale 1ns / 1ps

module ipag_pad_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ipag_pkg::DIM_W-1:0]    size,
  input  logic [ipag_pkg::STEP_W-1:0]   stride,
  input  logic [ipag_pkg::SPAN_W-1:0]   span,
  input  logic [ipag_pkg::MODE_W-1:0]   mode,
  output logic [ipag_pkg::SPAN_W-1:0]   pad,
  output logic                          busy
);
  import ipag_pkg::*;

  localparam int CNT_W = $clog2(DIM_W);

  typedef enum logic [2:0] {
    PS_IDLE = 3'b001,
    PS_RUN  = 3'b010,
    PS_FIN  = 3'b100
  } pad_state_t;

  pad_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [DIM_W-1:0]         div_r, div_nxt;
  logic [STEP_W-1:0]        rem_r, rem_nxt;
  logic [SPAN_W-1:0]        pad_r, pad_nxt;
  logic [STEP_W:0]          rem_sh;
  logic signed [TOT_W-1:0]  total;
  logic                     use_pad;

  assign rem_sh = {rem_r, div_r[DIM_W-1]};

  always_comb begin
    if (size == '0) begin
      total = $signed(TOT_W'(span)) - $signed(TOT_W'(stride));
    end else begin
      total = $signed(TOT_W'(span)) - $signed(TOT_W'(1)) - $signed(TOT_W'(rem_r));
    end
    use_pad = (mode == PAD_SAME_LOWER || mode == PAD_SAME_UPPER) &&
              (total > $signed(TOT_W'(0))) && (total < $signed(TOT_W'(span)));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    pad_nxt   = pad_r;
    if (start) begin
      state_nxt = PS_RUN;
      cnt_nxt   = '0;
      div_nxt   = size - DIM_W'(1);
      rem_nxt   = '0;
    end else begin
      unique case (state_r)
        PS_IDLE: ;
        PS_RUN: begin
          div_nxt = {div_r[DIM_W-2:0], 1'b0};
          if (rem_sh >= {1'b0, stride}) begin
            rem_nxt = STEP_W'(rem_sh - {1'b0, stride});
          end else begin
            rem_nxt = STEP_W'(rem_sh);
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIM_W - 1)) state_nxt = PS_FIN;
        end
        PS_FIN: begin
          if (use_pad) begin
            pad_nxt = SPAN_W'(total >>> 1) +
                      SPAN_W'(total[0] && (mode == PAD_SAME_LOWER));
          end else begin
            pad_nxt = '0;
          end
          state_nxt = PS_IDLE;
        end
        default: state_nxt = PS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_IDLE;
      pad_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pad_r   <= pad_nxt;
    end
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign pad  = pad_r;
  assign busy = (state_r != PS_IDLE);

endmodule

FILE: design/ipag_fifo.sv
// Short word queue between the front and back parts.
`timescale 1ns / 1ps

module ipag_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ipag_pkg::fq_word_t    push_word,
  input  logic                  pop,
  output ipag_pkg::fq_word_t    head_word,
  output logic                  empty,
  output logic                  full
);
  import ipag_pkg::*;

  fq_word_t            mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0]    wptr_r, wptr_nxt;
  logic [FQ_AW-1:0]    rptr_r, rptr_nxt;
  logic [FQ_AW:0]      count_r, count_nxt;

  assign empty     = (count_r == '0);
  assign full      = (count_r == (FQ_AW+1)'(FQ_DEPTH));
  assign head_word = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + FQ_AW'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + FQ_AW'(1) : rptr_r;
    count_nxt = count_r + (FQ_AW+1)'(push) - (FQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (push) mem_r[wptr_r] <= push_word;
  end

endmodule

FILE: design/ipag_front.sv
// Front part: configuration registers, padding setup and first product stage.
`timescale 1ns / 1ps

module ipag_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ipag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ipag_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ipag_pkg::in_word_t                in_word,
  output logic                              fq_push,
  output ipag_pkg::fq_word_t                fq_word,
  input  logic                              fq_full,
  output ipag_pkg::geom_t                   geom
);
  import ipag_pkg::*;

  logic [DIM_W-1:0]   height_r, width_r;
  logic [CH_W-1:0]    channels_r;
  logic [STEP_W-1:0]  stride_rows_r, stride_cols_r, rate_rows_r, rate_cols_r;
  logic [MODE_W-1:0]  pad_mode_r;
  logic               start_r;

  logic [STEP_W-1:0]  sh, sw, rh, rw;
  logic [SPAN_W-1:0]  span_rows, span_cols, pad_top, pad_left;
  logic               busy_top, busy_left, accept;
  logic [TAPI_W-1:0]  tap;

  logic               s1_valid_r, s1_valid_nxt;
  fq_word_t           s1_r, s1_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r      <= DIM_W'(1);
      width_r       <= DIM_W'(1);
      channels_r    <= CH_W'(1);
      stride_rows_r <= STEP_W'(1);
      stride_cols_r <= STEP_W'(1);
      rate_rows_r   <= STEP_W'(1);
      rate_cols_r   <= STEP_W'(1);
      pad_mode_r    <= PAD_VALID;
      start_r       <= 1'b0;
    end else begin
      start_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IN_HEIGHT:   height_r      <= cfg_wdata[DIM_W-1:0];
          CFG_IN_WIDTH:    width_r       <= cfg_wdata[DIM_W-1:0];
          CFG_IN_CHANNELS: channels_r    <= cfg_wdata[CH_W-1:0];
          CFG_STRIDE_ROWS: stride_rows_r <= cfg_wdata[STEP_W-1:0];
          CFG_STRIDE_COLS: stride_cols_r <= cfg_wdata[STEP_W-1:0];
          CFG_RATE_ROWS:   rate_rows_r   <= cfg_wdata[STEP_W-1:0];
          CFG_RATE_COLS:   rate_cols_r   <= cfg_wdata[STEP_W-1:0];
          CFG_PAD_MODE:    pad_mode_r    <= cfg_wdata[MODE_W-1:0];
        endcase
      end
    end
  end

  assign sh = (stride_rows_r == '0) ? STEP_W'(1) : stride_rows_r;
  assign sw = (stride_cols_r == '0) ? STEP_W'(1) : stride_cols_r;
  assign rh = (rate_rows_r == '0) ? STEP_W'(1) : rate_rows_r;
  assign rw = (rate_cols_r == '0) ? STEP_W'(1) : rate_cols_r;

  assign span_rows = SPAN_W'(KERNEL_H) + SPAN_W'((rh - STEP_W'(1)) * SPAN_W'(KERNEL_H - 1));
  assign span_cols = SPAN_W'(KERNEL_W) + SPAN_W'((rw - STEP_W'(1)) * SPAN_W'(KERNEL_W - 1));

  ipag_pad_unit u_pad_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .size   (height_r),
    .stride (sh),
    .span   (span_rows),
    .mode   (pad_mode_r),
    .pad    (pad_top),
    .busy   (busy_top)
  );

  ipag_pad_unit u_pad_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .size   (width_r),
    .stride (sw),
    .span   (span_cols),
    .mode   (pad_mode_r),
    .pad    (pad_left),
    .busy   (busy_left)
  );

  assign fq_push  = s1_valid_r && !fq_full;
  assign in_stall = start_r || busy_top || busy_left || (s1_valid_r && fq_full);
  assign accept   = in_valid && !in_stall;
  assign tap      = TAPI_W'(in_word.kernel_row) * TAPI_W'(KERNEL_W) +
                    TAPI_W'(in_word.kernel_col);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fq_push) begin
      s1_valid_nxt = 1'b0;
    end
    s1_nxt       = s1_r;
    if (accept) begin
      s1_nxt.rprod = RPROD_W'(in_word.out_row) * RPROD_W'(sh);
      s1_nxt.cprod = RPROD_W'(in_word.out_col) * RPROD_W'(sw);
      s1_nxt.rtap  = TPROD_W'(in_word.kernel_row) * TPROD_W'(rh);
      s1_nxt.ctap  = TPROD_W'(in_word.kernel_col) * TPROD_W'(rw);
      s1_nxt.bc    = BC_W'(batch_mod(in_word.batch)) * BC_W'(channels_r);
      s1_nxt.chan  = in_word.channel;
      s1_nxt.och   = OCH_W'(OCHP_W'(tap) * OCHP_W'(channels_r) +
                            OCHP_W'(in_word.channel));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_r <= s1_nxt;
  end

  assign fq_word       = s1_r;
  assign geom.height   = height_r;
  assign geom.width    = width_r;
  assign geom.pad_top  = pad_top;
  assign geom.pad_left = pad_left;

endmodule

FILE: design/ipag_back.sv
// Back part: bounds check, index products and the output register.
`timescale 1ns / 1ps

module ipag_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipag_pkg::geom_t       geom,
  input  logic                  fq_empty,
  input  ipag_pkg::fq_word_t    fq_word,
  output logic                  fq_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ipag_pkg::out_word_t   out_word
);
  import ipag_pkg::*;

  logic                     adv;
  logic signed [ROW_W-1:0]  row, col;
  logic                     row_in, col_in;
  logic [P2_W-1:0]          p2;
  logic [P2_W+DIM_W-1:0]    p3;

  logic                     b2_valid_r, b3_valid_r, out_valid_r;
  logic                     b2_pad_r, b3_pad_r;
  logic [DIM_W-1:0]         b2_row_r, b2_col_r, b3_col_r;
  logic [P2_W-1:0]          b2_p2_r;
  logic [SRC_W-1:0]         b3_t_r;
  logic [OCH_W-1:0]         b2_och_r, b3_och_r;
  out_word_t                out_r, out_nxt;

  assign adv    = !out_valid_r || !out_stall;
  assign fq_pop = adv && !fq_empty;

  always_comb begin
    row = $signed(ROW_W'(fq_word.rprod)) - $signed(ROW_W'(geom.pad_top)) +
          $signed(ROW_W'(fq_word.rtap));
    col = $signed(ROW_W'(fq_word.cprod)) - $signed(ROW_W'(geom.pad_left)) +
          $signed(ROW_W'(fq_word.ctap));
    row_in = !row[ROW_W-1] && (row[ROW_W-2:0] < (ROW_W-1)'(geom.height));
    col_in = !col[ROW_W-1] && (col[ROW_W-2:0] < (ROW_W-1)'(geom.width));
    p2 = P2_W'(BCC_W'(fq_word.bc) + BCC_W'(fq_word.chan)) * P2_W'(geom.height);
    p3 = (P2_W+DIM_W)'(b2_p2_r + P2_W'(b2_row_r)) * (P2_W+DIM_W)'(geom.width);
    out_nxt.src_index   = b3_pad_r ? '0 : b3_t_r + SRC_W'(b3_col_r);
    out_nxt.is_padding  = b3_pad_r;
    out_nxt.out_channel = b3_och_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r  <= 1'b0;
      b3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b2_valid_r  <= !fq_empty;
      b3_valid_r  <= b2_valid_r;
      out_valid_r <= b3_valid_r;
    end
    if (adv) begin
      b2_pad_r <= !(row_in && col_in);
      b2_row_r <= row[DIM_W-1:0];
      b2_col_r <= col[DIM_W-1:0];
      b2_p2_r  <= p2;
      b2_och_r <= fq_word.och;
      b3_pad_r <= b2_pad_r;
      b3_t_r   <= p3[SRC_W-1:0];
      b3_col_r <= b2_col_r;
      b3_och_r <= b2_och_r;
      out_r    <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

FILE: design/image_patch_address_generator.sv
// Top level of the dilated image patch address generator.
`timescale 1ns / 1ps

// Takes one patch element word per cycle (batch, output row and column, kernel tap,
// channel) and returns the flat NCHW source index of that tap, or a padding flag with
// a zero index, plus the output channel the tap fills. Sustained rate is one word per
// clock while neither in_stall nor out_stall holds the flow; a word passes from input
// to output through the product stage, the four-entry queue, two back stages and the
// output register. Every configuration write restarts two bit-serial remainder units
// that derive the top and left padding, one dividend bit per cycle; the input stalls
// after the last write until they finish.
module image_patch_address_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ipag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ipag_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ipag_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ipag_pkg::out_word_t               out_word
);
  import ipag_pkg::*;

  logic      fq_push, fq_pop, fq_empty, fq_full;
  fq_word_t  fq_in_word, fq_head_word;
  geom_t     geom;

  ipag_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .fq_push   (fq_push),
    .fq_word   (fq_in_word),
    .fq_full   (fq_full),
    .geom      (geom)
  );

  ipag_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_word (fq_in_word),
    .pop       (fq_pop),
    .head_word (fq_head_word),
    .empty     (fq_empty),
    .full      (fq_full)
  );

  ipag_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .fq_empty  (fq_empty),
    .fq_word   (fq_head_word),
    .fq_pop    (fq_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
